// ----- src/interlaced_scan_address_generator_unit_macros.svh -----
// Assertion macros for the interlaced scan address generator.
// Used by interlaced_scan_address_generator_unit; needs a clk and rst_n in scope.
`ifndef INTERLACED_SCAN_ADDRESS_GENERATOR_UNIT_MACROS_SVH
`define INTERLACED_SCAN_ADDRESS_GENERATOR_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define ISAG_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset
`define ISAG_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/isag_pkg.sv -----
// Shared types, widths and helpers for the interlaced scan address generator.
// No dependencies.
`timescale 1ns / 1ps

package isag_pkg;

    localparam int unsigned DIM_W   = 16;
    localparam int unsigned LEVEL_W = 3;
    localparam int unsigned COUNT_W = 32;
    localparam int unsigned PIXEL_W = 64;
    localparam int unsigned APB_AW  = 4;
    localparam int unsigned APB_DW  = 32;

    localparam logic [LEVEL_W-1:0] MAX_LEVEL = 3'd6;

    typedef enum logic [1:0] {
        REG_FRAME_WIDTH     = 2'd0,
        REG_FRAME_HEIGHT    = 2'd1,
        REG_INTERLACE_LEVEL = 2'd2
    } reg_idx_t;

    typedef enum logic [1:0] {
        ST_IDLE   = 2'b01,
        ST_SEARCH = 2'b10
    } state_t;

    // Clamp the programmed level to the deepest supported grid
    function automatic logic [LEVEL_W-1:0] clamp_level(input logic [LEVEL_W-1:0] lvl);
        return (lvl > MAX_LEVEL) ? MAX_LEVEL : lvl;
    endfunction

endpackage

// ----- src/interlaced_scan_address_generator_unit.sv -----
// Interlaced scan address generator: a request is accepted in IDLE and placed from SEARCH
// once the grid point is new and the output register is free; skipped points are stepped past.
// Requests are taken one at a time (in_ready only in IDLE), and the single advance unit
// (one grid step per cycle) steps the scan under the two-state sequencer.
// Reset (rst_n low, async): width = height = 1, level 0, frame restarted, no result.
// Depends on isag_pkg and interlaced_scan_address_generator_unit_macros.svh.
`timescale 1ns / 1ps

`include "interlaced_scan_address_generator_unit_macros.svh"

module interlaced_scan_address_generator_unit
    import isag_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    // APB-style configuration port
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [APB_AW-1:0]         paddr,
    input  logic [APB_DW-1:0]         pwdata,
    output logic [APB_DW-1:0]         prdata,
    output logic                      pready,
    // Pixel input channel
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [PIXEL_W-1:0]        pixel_data,
    // Placed pixel output channel
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [PIXEL_W-1:0]        pixel_out,
    output logic [DIM_W-1:0]          pos_x,
    output logic [DIM_W-1:0]          pos_y,
    output logic                      last_pixel,
    output logic                      overflow
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [DIM_W-1:0]   frame_width_reg;
    logic [DIM_W-1:0]   frame_height_reg;
    logic [LEVEL_W-1:0] interlace_level_reg;
    logic [COUNT_W-1:0] total_reg;      // width * height, registered after the multiply

    reg_idx_t           cfg_idx;
    logic               cfg_write;
    logic               cfg_hit;
    logic [LEVEL_W-1:0] restart_level;

    assign pready    = 1'b1;
    assign cfg_idx   = reg_idx_t'(paddr[APB_AW-1:2]);
    assign cfg_write = psel && penable && pwrite;

    // Decode which register a write hits; a write beyond the map is dropped
    always_comb
    begin
        cfg_hit       = 1'b0;
        restart_level = clamp_level(interlace_level_reg);
        case (cfg_idx)
            REG_FRAME_WIDTH:
            begin
                cfg_hit = 1'b1;
            end
            REG_FRAME_HEIGHT:
            begin
                cfg_hit = 1'b1;
            end
            REG_INTERLACE_LEVEL:
            begin
                cfg_hit       = 1'b1;
                // A level write restarts at the new level
                restart_level = clamp_level(pwdata[LEVEL_W-1:0]);
            end
            default:
            begin
                cfg_hit = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        case (cfg_idx)
            REG_FRAME_WIDTH:     prdata = APB_DW'(frame_width_reg);
            REG_FRAME_HEIGHT:    prdata = APB_DW'(frame_height_reg);
            REG_INTERLACE_LEVEL: prdata = APB_DW'(interlace_level_reg);
            default:             prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg     <= DIM_W'(1);
            frame_height_reg    <= DIM_W'(1);
            interlace_level_reg <= '0;
            total_reg           <= COUNT_W'(1);
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_idx)
                    REG_FRAME_WIDTH:     frame_width_reg     <= pwdata[DIM_W-1:0];
                    REG_FRAME_HEIGHT:    frame_height_reg    <= pwdata[DIM_W-1:0];
                    REG_INTERLACE_LEVEL: interlace_level_reg <= pwdata[LEVEL_W-1:0];
                    default:             ;
                endcase
            end
            // Frame size is registered from the width and height registers; a request accepted
            // right after a write is checked in SEARCH, by which time this is fresh.
            total_reg <= COUNT_W'(frame_width_reg) * COUNT_W'(frame_height_reg);
        end
    end

    // ------------------------------------------------------------------
    // Scan state and sequencer
    // ------------------------------------------------------------------
    state_t             state_reg,       state_next;
    logic [DIM_W-1:0]   cur_x_reg,       cur_x_next;
    logic [DIM_W-1:0]   cur_y_reg,       cur_y_next;
    logic [LEVEL_W-1:0] pass_level_reg,  pass_level_next;
    logic [COUNT_W-1:0] pixel_count_reg, pixel_count_next;
    logic [PIXEL_W-1:0] pixel_reg,       pixel_next;

    // Output register
    logic               out_valid_reg,   out_valid_next;
    logic [PIXEL_W-1:0] pixel_out_reg,   pixel_out_next;
    logic [DIM_W-1:0]   pos_x_reg,       pos_x_next;
    logic [DIM_W-1:0]   pos_y_reg,       pos_y_next;
    logic               last_pixel_reg,  last_pixel_next;
    logic               overflow_reg,    overflow_next;

    // Shared advance unit: one grid step with row and pass wrap
    logic [DIM_W:0]     step;
    logic [DIM_W:0]     x_sum;
    logic [DIM_W:0]     y_sum;
    logic [DIM_W-1:0]   adv_x;
    logic [DIM_W-1:0]   adv_y;
    logic [LEVEL_W-1:0] adv_level;

    always_comb
    begin
        step      = (DIM_W+1)'(1) << pass_level_reg;
        x_sum     = {1'b0, cur_x_reg} + step;
        y_sum     = {1'b0, cur_y_reg} + step;
        adv_x     = x_sum[DIM_W-1:0];
        adv_y     = cur_y_reg;
        adv_level = pass_level_reg;
        if (x_sum >= {1'b0, frame_width_reg})
        begin
            // Wrap to the next grid row
            adv_x = '0;
            adv_y = y_sum[DIM_W-1:0];
            if (y_sum >= {1'b0, frame_height_reg})
            begin
                // Wrap to the next, finer pass
                adv_y = '0;
                if (pass_level_reg != '0)
                begin
                    adv_level = pass_level_reg - LEVEL_W'(1);
                end
            end
        end
    end

    // New-point test: first pass takes every grid point, later passes only odd ones
    logic [DIM_W-1:0]   x_shift;
    logic [DIM_W-1:0]   y_shift;
    logic               is_new;
    logic               frame_full;
    logic [COUNT_W-1:0] count_inc;
    logic               slot_free;

    assign x_shift    = cur_x_reg >> pass_level_reg;
    assign y_shift    = cur_y_reg >> pass_level_reg;
    assign is_new     = (pass_level_reg >= clamp_level(interlace_level_reg))
                        || x_shift[0] || y_shift[0];
    assign frame_full = (pixel_count_reg >= total_reg);
    assign count_inc  = pixel_count_reg + COUNT_W'(1);
    assign slot_free  = !out_valid_reg || out_ready;

    assign in_ready   = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next       = state_reg;
        cur_x_next       = cur_x_reg;
        cur_y_next       = cur_y_reg;
        pass_level_next  = pass_level_reg;
        pixel_count_next = pixel_count_reg;
        pixel_next       = pixel_reg;

        out_valid_next   = out_valid_reg && !out_ready;
        pixel_out_next   = pixel_out_reg;
        pos_x_next       = pos_x_reg;
        pos_y_next       = pos_y_reg;
        last_pixel_next  = last_pixel_reg;
        overflow_next    = overflow_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    // Take the request and start the search
                    pixel_next = pixel_data;
                    state_next = ST_SEARCH;
                end
            end
            ST_SEARCH:
            begin
                if (frame_full)
                begin
                    // Frame already complete: flag overflow, leave the scan alone
                    if (slot_free)
                    begin
                        out_valid_next  = 1'b1;
                        pixel_out_next  = pixel_reg;
                        pos_x_next      = '0;
                        pos_y_next      = '0;
                        last_pixel_next = 1'b0;
                        overflow_next   = 1'b1;
                        state_next      = ST_IDLE;
                    end
                end
                else if (is_new)
                begin
                    // Place the pixel once the output register can take it
                    if (slot_free)
                    begin
                        out_valid_next   = 1'b1;
                        pixel_out_next   = pixel_reg;
                        pos_x_next       = cur_x_reg;
                        pos_y_next       = cur_y_reg;
                        last_pixel_next  = (count_inc == total_reg);
                        overflow_next    = 1'b0;
                        pixel_count_next = count_inc;
                        state_next       = ST_IDLE;
                        if (count_inc == total_reg)
                        begin
                            cur_x_next      = '0;
                            cur_y_next      = '0;
                            pass_level_next = '0;
                        end
                        else
                        begin
                            cur_x_next      = adv_x;
                            cur_y_next      = adv_y;
                            pass_level_next = adv_level;
                        end
                    end
                end
                else
                begin
                    // Point already covered by a coarser pass: skip it
                    cur_x_next      = adv_x;
                    cur_y_next      = adv_y;
                    pass_level_next = adv_level;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Any register write restarts the frame
        if (cfg_write && cfg_hit)
        begin
            cur_x_next       = '0;
            cur_y_next       = '0;
            pass_level_next  = restart_level;
            pixel_count_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            cur_x_reg       <= '0;
            cur_y_reg       <= '0;
            pass_level_reg  <= '0;
            pixel_count_reg <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            cur_x_reg       <= cur_x_next;
            cur_y_reg       <= cur_y_next;
            pass_level_reg  <= pass_level_next;
            pixel_count_reg <= pixel_count_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // Payload registers: no reset needed
    always_ff @(posedge clk)
    begin
        pixel_reg      <= pixel_next;
        pixel_out_reg  <= pixel_out_next;
        pos_x_reg      <= pos_x_next;
        pos_y_reg      <= pos_y_next;
        last_pixel_reg <= last_pixel_next;
        overflow_reg   <= overflow_next;
    end

    assign out_valid  = out_valid_reg;
    assign pixel_out  = pixel_out_reg;
    assign pos_x      = pos_x_reg;
    assign pos_y      = pos_y_reg;
    assign last_pixel = last_pixel_reg;
    assign overflow   = overflow_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `ISAG_ASSERT_NEXT(a_accept_starts_search, in_valid && in_ready,
        state_reg == ST_SEARCH, "accepted request did not start the search")

    `ISAG_ASSERT_NOW(a_overflow_result_clean, out_valid && overflow,
        !last_pixel && pos_x == '0 && pos_y == '0, "overflow result carries a position")

    `ISAG_ASSERT_NOW(a_level_in_range, 1'b1,
        pass_level_reg <= MAX_LEVEL, "pass level beyond the deepest grid")

    `ISAG_ASSERT_NOW(a_result_from_search, $rose(out_valid_reg),
        $past(state_reg == ST_SEARCH), "result appeared without a search")

endmodule
